// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/crcfpe_pkg.sv =====
`default_nettype none

package crcfpe_pkg;

    // largest payload a header may announce
    localparam int unsigned MAX_PAYLOAD = 256;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // input item kinds carried on tuser
    localparam logic OP_HEADER  = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_START_MARKER = 2'd0;
    localparam logic [1:0] CFG_END_MARKER   = 2'd1;

    // output sequencer steps
    typedef enum logic [2:0] {
        STEP_START,
        STEP_CMD,
        STEP_LEN_LO,
        STEP_LEN_HI,
        STEP_CRC_LO,
        STEP_CRC_HI,
        STEP_END
    } step_t;

    // one byte of crc-16/xmodem, msb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/crc16_framed_packet_encoder.sv =====
// Framed packet encoder with CRC-16/XMODEM. A header item (tuser 0) opens a
// frame and yields start marker, command, length low and length high bytes;
// each payload item (tuser 1) passes its byte through. After the last payload
// byte, or right after a zero-length header, the CRC low byte, CRC high byte
// and end marker follow; tlast marks the final byte caused by each item and
// m_tuser marks the end marker. Items are taken into a one-deep job register
// and a sequencer moves one byte per cycle into the output register while the
// receiver does not stall it; the next item is taken as the current one emits
// its final byte. A dropped item (out-of-order or too long) gives no output.
`default_nettype none

`include "assert_macros.svh"

module crc16_framed_packet_encoder
    import crcfpe_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // command[7:0], payload_length[16:8], data_byte[24:17]
    input  wire logic        s_tuser,  // opcode[0]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,  // out_byte[7:0]
    output logic             m_tlast,
    output logic             m_tuser,  // frame_end[0]
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    // job register
    logic        job_valid_reg, job_valid_next;
    logic        job_opcode_reg;
    logic [7:0]  job_command_reg;
    logic [8:0]  job_length_reg;
    logic [7:0]  job_data_reg;
    step_t       step_reg, step_next;

    // frame state
    logic [15:0] crc_reg;
    logic [8:0]  remaining_reg;
    logic        in_frame_reg;
    logic [7:0]  start_marker_reg;
    logic [7:0]  end_marker_reg;

    // output register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_end_reg;

    logic        accept;
    logic        out_free;
    logic        header_ok;
    logic        drop;
    logic        emit;
    logic        final_step;
    logic        job_done;
    logic [7:0]  result_byte;
    logic        result_last;
    logic        result_end;

    // handshake and sequencing control
    assign out_free  = !out_valid_reg || m_tready;
    assign header_ok = !in_frame_reg && (32'(job_length_reg) <= MAX_PAYLOAD);
    assign drop      = job_valid_reg && (step_reg == STEP_START) &&
                       ((job_opcode_reg == OP_HEADER) ? !header_ok : !in_frame_reg);
    assign emit      = job_valid_reg && !drop && out_free;
    assign job_done  = drop || (emit && final_step);
    assign s_tready  = !job_valid_reg || job_done;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign job_valid_next = accept ? 1'b1 : (job_done ? 1'b0 : job_valid_reg);

    // next step
    always_comb begin
        step_next = step_reg;
        if (accept) begin
            step_next = STEP_START;
        end else if (emit) begin
            unique case (step_reg)
                STEP_START:  step_next = (job_opcode_reg == OP_HEADER) ? STEP_CMD : STEP_CRC_LO;
                STEP_CMD:    step_next = STEP_LEN_LO;
                STEP_LEN_LO: step_next = STEP_LEN_HI;
                STEP_LEN_HI: step_next = STEP_CRC_LO;
                STEP_CRC_LO: step_next = STEP_CRC_HI;
                STEP_CRC_HI: step_next = STEP_END;
                STEP_END:    step_next = STEP_START;
                default:     step_next = STEP_START;
            endcase
        end
    end

    // byte and flags for the current step
    always_comb begin
        result_byte = 8'h00;
        result_last = 1'b0;
        result_end  = 1'b0;
        final_step  = 1'b0;
        unique case (step_reg)
            STEP_START: begin
                if (job_opcode_reg == OP_HEADER) begin
                    result_byte = start_marker_reg;
                end else begin
                    result_byte = job_data_reg;
                    result_last = (remaining_reg != 9'd1);
                    final_step  = (remaining_reg != 9'd1);
                end
            end
            STEP_CMD:    result_byte = job_command_reg;
            STEP_LEN_LO: result_byte = job_length_reg[7:0];
            STEP_LEN_HI: begin
                result_byte = {7'd0, job_length_reg[8]};
                result_last = (job_length_reg != 9'd0);
                final_step  = (job_length_reg != 9'd0);
            end
            STEP_CRC_LO: result_byte = crc_reg[7:0];
            STEP_CRC_HI: result_byte = crc_reg[15:8];
            STEP_END: begin
                result_byte = end_marker_reg;
                result_last = 1'b1;
                result_end  = 1'b1;
                final_step  = 1'b1;
            end
            default: result_byte = 8'h00;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg    <= 1'b0;
            step_reg         <= STEP_START;
            out_valid_reg    <= 1'b0;
            crc_reg          <= 16'h0000;
            remaining_reg    <= 9'd0;
            in_frame_reg     <= 1'b0;
            start_marker_reg <= 8'd2;
            end_marker_reg   <= 8'd3;
        end else begin
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;

            // output register load and drain
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            // frame state follows the bytes as they leave
            if (emit) begin
                case (step_reg)
                    STEP_START: begin
                        if (job_opcode_reg == OP_PAYLOAD) begin
                            crc_reg       <= crc16_update(crc_reg, job_data_reg);
                            remaining_reg <= remaining_reg - 9'd1;
                            if (remaining_reg == 9'd1) begin
                                in_frame_reg <= 1'b0;
                            end
                        end
                    end
                    STEP_CMD:    crc_reg <= crc16_update(16'h0000, job_command_reg);
                    STEP_LEN_LO: crc_reg <= crc16_update(crc_reg, job_length_reg[7:0]);
                    STEP_LEN_HI: begin
                        crc_reg <= crc16_update(crc_reg, {7'd0, job_length_reg[8]});
                        if (job_length_reg != 9'd0) begin
                            in_frame_reg  <= 1'b1;
                            remaining_reg <= job_length_reg;
                        end
                    end
                    STEP_END:    crc_reg <= 16'h0000;
                    default:     crc_reg <= crc_reg;
                endcase
            end

            // configuration writes
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_START_MARKER: start_marker_reg <= cfg_data;
                    CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                    default:          start_marker_reg <= start_marker_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            job_opcode_reg  <= s_tuser;
            job_command_reg <= s_tdata[7:0];
            job_length_reg  <= s_tdata[16:8];
            job_data_reg    <= s_tdata[24:17];
        end
        if (emit) begin
            out_byte_reg <= result_byte;
            out_last_reg <= result_last;
            out_end_reg  <= result_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

    // checks
    `ASSERT_SAME(a_ready_only_when_done, aclk, aresetn,
        s_tready && job_valid_reg, job_done, "input taken while job still busy")
    `ASSERT_SAME(a_end_is_last, aclk, aresetn,
        m_tvalid && m_tuser, m_tlast, "end marker not marked last")
    `ASSERT_SAME(a_frame_has_bytes, aclk, aresetn,
        in_frame_reg, remaining_reg != 9'd0, "open frame with nothing left")
    `ASSERT_NEXT(a_end_clears_state, aclk, aresetn,
        emit && (step_reg == STEP_END), !in_frame_reg && (crc_reg == 16'h0000),
        "frame state not cleared after end marker")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

import crcfpe_pkg::*;

// tracks the frame state and holds the bytes the encoder should emit next
class frame_byte_tracker;
    typedef struct packed {
        logic [7:0] obyte;
        logic       last;
        logic       frame_end;
    } out_item_t;

    out_item_t   expected_bytes[$];
    logic [7:0]  start_mk;
    logic [7:0]  end_mk;
    logic [15:0] crc_acc;
    logic [8:0]  left;
    bit          open;
    int          errors;
    int          items_in;
    int          dropped;
    int          results_seen;
    int          frames_closed;

    function void reset_state();
        start_mk = 8'h02;
        end_mk   = 8'h03;
        crc_acc  = 16'h0000;
        left     = 9'd0;
        open     = 1'b0;
        expected_bytes.delete();
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] v);
        if (idx == CFG_START_MARKER) begin
            start_mk = v;
        end else if (idx == CFG_END_MARKER) begin
            end_mk = v;
        end
    endfunction

    // xmodem crc, one data bit at a time
    function logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] d);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ d[i];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

    function void push(logic [7:0] b, logic l, logic e);
        out_item_t x;
        x.obyte     = b;
        x.last      = l;
        x.frame_end = e;
        expected_bytes.push_back(x);
    endfunction

    // crc low, crc high, end marker
    function void close_frame();
        push(crc_acc[7:0], 1'b0, 1'b0);
        push(crc_acc[15:8], 1'b0, 1'b0);
        push(end_mk, 1'b1, 1'b1);
        open     = 1'b0;
        left     = 9'd0;
        crc_acc  = 16'h0000;
        frames_closed++;
    endfunction

    function void note_input(logic op, logic [7:0] cmd, logic [8:0] len, logic [7:0] d);
        int n0;
        n0 = expected_bytes.size();
        items_in++;
        if (op == OP_HEADER) begin
            if (!open && len <= MAX_PAYLOAD) begin
                crc_acc = crc_byte(crc_byte(crc_byte(16'h0000, cmd), len[7:0]),
                                   {7'd0, len[8]});
                push(start_mk, 1'b0, 1'b0);
                push(cmd, 1'b0, 1'b0);
                push(len[7:0], 1'b0, 1'b0);
                if (len == 9'd0) begin
                    push({7'd0, len[8]}, 1'b0, 1'b0);
                    close_frame();
                end else begin
                    push({7'd0, len[8]}, 1'b1, 1'b0);
                    open = 1'b1;
                    left = len;
                end
            end
        end else if (open) begin
            crc_acc = crc_byte(crc_acc, d);
            left    = left - 9'd1;
            if (left != 9'd0) begin
                push(d, 1'b1, 1'b0);
            end else begin
                push(d, 1'b0, 1'b0);
                close_frame();
            end
        end
        if (expected_bytes.size() == n0) begin
            dropped++;
        end
    endfunction

    function void check_result(logic [7:0] b, logic l, logic e);
        out_item_t x;
        results_seen++;
        if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected output item: expected none, actual byte %02h last %0b end %0b",
                     $time, b, l, e);
            return;
        end
        x = expected_bytes.pop_front();
        if (x.obyte !== b) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %02h actual %02h", $time, x.obyte, b);
        end
        if (x.last !== l) begin
            errors++;
            $display("%0t: last_of_run mismatch: expected %0b actual %0b", $time, x.last, l);
        end
        if (x.frame_end !== e) begin
            errors++;
            $display("%0t: frame_end mismatch: expected %0b actual %0b", $time, x.frame_end, e);
        end
    endfunction
endclass

module tb_top;
    localparam int STALL_LIMIT = 2000;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = 32'd0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [7:0]  cfg_data  = 8'd0;

    int tx_idle_pct = 7;
    int rx_idle_pct = 88;
    int stall_cycles = 0;

    frame_byte_tracker sb = new();

    crc16_framed_packet_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // output check and stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast, m_tuser);
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one input item, with idle cycles ahead of it at the sender's idle rate
    task automatic send_item(input logic op, input logic [7:0] cmd, input logic [8:0] len,
                             input logic [7:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, d, len, cmd};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, cmd, len, d);
    endtask

    task automatic send_header(input logic [7:0] cmd, input logic [8:0] len);
        send_item(OP_HEADER, cmd, len, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] d);
        send_item(OP_PAYLOAD, 8'($urandom), 9'($urandom), d);
    endtask

    // payload bytes, sometimes equal to a marker
    function automatic logic [7:0] pick_data();
        int r;
        r = $urandom_range(99);
        if (r < 5) begin
            return sb.start_mk;
        end else if (r < 10) begin
            return sb.end_mk;
        end
        return 8'($urandom);
    endfunction

    function automatic logic [8:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            return 9'($urandom_range(0, 3));
        end else if (r < 85) begin
            return 9'($urandom_range(4, 16));
        end
        return 9'($urandom_range(17, 48));
    endfunction

    task automatic finish_open_frame();
        while (sb.open) begin
            send_payload(pick_data());
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge aclk);
        // a dropped item may still be inside the block
        repeat (12) @(posedge aclk);
    endtask

    task automatic write_markers(input logic [7:0] smk, input logic [7:0] emk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_START_MARKER;
        cfg_data  <= smk;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(CFG_START_MARKER, smk);
        cfg_index <= CFG_END_MARKER;
        cfg_data  <= emk;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(CFG_END_MARKER, emk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly well-formed frames, with stray and broken items mixed in
    task automatic run_random(input int budget);
        int done;
        int r;
        int n;
        logic [8:0] len;
        done = 0;
        while (done < budget) begin
            r = $urandom_range(99);
            if (r < 85) begin
                len = pick_len();
                send_header(8'($urandom), len);
                done++;
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(99) < 4) begin
                        send_header(8'($urandom), 9'($urandom));
                    end
                    send_payload(pick_data());
                    done++;
                end
            end else if (r < 90) begin
                send_payload(8'($urandom));
            end else if (r < 95) begin
                send_header(8'($urandom), 9'($urandom_range(MAX_PAYLOAD + 1, 511)));
            end else begin
                // frame cut short: later items land in it
                len = 9'($urandom_range(2, 8));
                send_header(8'($urandom), len);
                n = $urandom_range(0, len - 1);
                repeat (n) send_payload(pick_data());
                done += n + 1;
            end
        end
        finish_open_frame();
    endtask

    initial begin
        sb.reset_state();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed items with the reset markers
        send_payload(8'hFF);
        send_header(8'h00, 9'd0);
        send_header(8'hFF, 9'd0);
        send_header(8'h5A, 9'd257);
        send_header(8'h11, 9'd511);
        send_header(8'h3C, 9'd3);
        send_header(8'h77, 9'd1);
        send_payload(8'h02);
        send_payload(8'h03);
        send_payload(8'hFF);
        send_header(8'hA5, 9'd1);
        send_payload(8'h00);
        send_header(8'h80, 9'd2);
        send_payload(8'h01);
        send_payload(8'hFE);
        drain();

        // sender mostly busy, receiver mostly stalled
        write_markers(8'h00, 8'hFF);
        run_random(70);
        drain();

        // sender mostly idle, receiver mostly ready
        tx_idle_pct = 88;
        rx_idle_pct = 7;
        write_markers(8'hFF, 8'h00);
        run_random(70);
        drain();

        // full rate both sides, largest frame first
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_markers(8'($urandom), 8'($urandom));
        send_header(8'($urandom), 9'(MAX_PAYLOAD));
        repeat (MAX_PAYLOAD) send_payload(pick_data());
        run_random(70);
        drain();

        if (sb.expected_bytes.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d output items never arrived", $time, sb.expected_bytes.size());
        end
        $display("run covered %0d input items (%0d dropped) and %0d output items",
                 sb.items_in, sb.dropped, sb.results_seen);
        $display("%0d frames closed over four marker settings and three idle patterns",
                 sb.frames_closed);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
